### src/pcd_pkg.sv
// Package for the PDM-to-PCM CIC decimator: shared types, constants and the
// per-byte integrator contribution function. No dependencies.
`default_nettype none

package pcd_pkg;

  // Depth of the queue between the integrator front and the filter back.
  localparam int FifoDepth = 4;
  localparam int FifoAw = $clog2(FifoDepth);

  // Shift amounts of the filter chain.
  localparam int HpShift = 10;
  localparam int LpShift = 2;
  localparam int OutShift = 6;

  localparam logic signed [31:0] PcmMax = 32'sd32767;
  localparam logic signed [31:0] PcmMin = -32'sd32768;

  // Register indexes on the configuration port.
  localparam logic RegDecimation = 1'b0;
  localparam logic RegSampleLimit = 1'b1;

  // Contributions of one PDM byte to the three integrators.
  typedef struct packed {
    logic signed [4:0] t1;
    logic signed [6:0] t2;
    logic signed [7:0] t3;
  } pcd_terms_t;

  typedef struct packed {
    logic full;
    logic empty;
  } pcd_fifo_stat_t;

  // Bit 0 is the oldest bit and stays in all eight integration steps.
  function automatic pcd_terms_t byte_terms(input logic [7:0] b);
    pcd_terms_t r;
    int s1;
    int s2;
    int s3;
    int n;
    int tri_sum;
    s1 = 0;
    s2 = 0;
    s3 = 0;
    for (int k = 0; k < 8; k++) begin
      n = 8 - k;
      tri_sum = (n * (n + 1)) / 2;
      if (b[k]) begin
        s1 = s1 + 1;
        s2 = s2 + n;
        s3 = s3 + tri_sum;
      end else begin
        s1 = s1 - 1;
        s2 = s2 - n;
        s3 = s3 - tri_sum;
      end
    end
    r.t1 = 5'(s1);
    r.t2 = 7'(s2);
    r.t3 = 8'(s3);
    return r;
  endfunction

endpackage

`default_nettype wire

### src/pdm_cic_decimator_top.sv
// Top level of the PDM-to-PCM third-order CIC decimator: APB register file,
// integrator front, queue and filter back. Uses pcd_pkg, pcd_front, pcd_fifo, pcd_back.
`default_nettype none

// Each transfer on the slave stream carries one byte of PDM bits, bit 0 the
// oldest, a set bit counting +1 and a clear bit -1. The block takes one byte
// every clock cycle while s_tready is high: the front advances three 32-bit
// wrapping integrators by all eight bits at once, and every decimation_bytes
// bytes it hands the third integrator to a four-entry queue. While the
// output register can load, the back takes one queue entry per cycle through
// three registered comb stages, a DC-blocking high-pass (y = x - x1 + y1 -
// (y1 >>> 10)), a quarter-weight exponential low-pass, a shift right by 6
// and saturation to a signed 16-bit PCM sample. The combs, high-pass,
// low-pass and output are each registered. The output register frees the
// input side: s_tready drops only when the queue fills, which happens only
// while the master side holds off. Once sample_limit samples have gone out,
// the combs keep tracking the input but no further samples appear and the
// high-pass and low-pass state freezes. Registers: decimation_bytes at byte
// address 0 (7 bits, reset 4, zero behaves as one) and sample_limit at byte
// address 4 (16 bits, reset 31500). Write them only while the block is idle.
module pdm_cic_decimator_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] pdm_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [15:0] pcm_sample
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [6:0]  decimation_bytes;
  logic [15:0] sample_limit;
  logic        reg_write;
  logic        reg_index;
  logic        push;
  logic        pop;
  logic [31:0] push_data;
  logic [31:0] pop_data;
  pcd_pkg::pcd_fifo_stat_t stat;

  // Configuration port: no wait states; the register index is address bit 2.
  assign pready = 1'b1;
  assign reg_write = psel && penable && pwrite && pready;
  assign reg_index = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      decimation_bytes <= 7'd4;
      sample_limit <= 16'd31500;
    end else if (reg_write) begin
      case (reg_index)
        pcd_pkg::RegDecimation:  decimation_bytes <= pwdata[6:0];
        pcd_pkg::RegSampleLimit: sample_limit <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      pcd_pkg::RegDecimation:  prdata = {25'd0, decimation_bytes};
      pcd_pkg::RegSampleLimit: prdata = {16'd0, sample_limit};
      default:                 prdata = '0;
    endcase
  end

  pcd_front u_front (
    .clk              (clk),
    .rst              (rst),
    .s_tvalid         (s_tvalid),
    .s_tready         (s_tready),
    .s_tdata          (s_tdata),
    .decimation_bytes (decimation_bytes),
    .stat             (stat),
    .push             (push),
    .push_data        (push_data)
  );

  pcd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (stat)
  );

  pcd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .stat         (stat),
    .pop          (pop),
    .pop_data     (pop_data),
    .sample_limit (sample_limit),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata)
  );

endmodule

`default_nettype wire

### src/pcd_front.sv
// Integrator front of the decimator: accepts PDM bytes, runs the three
// integrators and pushes the third integrator at each decimation point. Uses pcd_pkg.
`default_nettype none

module pcd_front (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [7:0]             s_tdata,    // [7:0] pdm_byte
  input  wire logic [6:0]             decimation_bytes,
  input  wire pcd_pkg::pcd_fifo_stat_t stat,
  output logic                        push,
  output logic [31:0]                 push_data
);

  logic [31:0] integ_one;
  logic [31:0] integ_two;
  logic [31:0] integ_three;
  logic [31:0] integ_one_next;
  logic [31:0] integ_two_next;
  logic [31:0] integ_three_next;
  logic [6:0]  byte_counter;
  logic [6:0]  byte_counter_next;
  logic        accept;
  logic        fire;
  pcd_pkg::pcd_terms_t terms;

  assign s_tready = !stat.full;
  assign accept = s_tvalid && s_tready;
  assign terms = pcd_pkg::byte_terms(s_tdata);

  // All three updates use the integrator values from before this byte.
  always_comb begin
    integ_three_next = integ_three + (integ_two << 3) + (integ_one << 5) + (integ_one << 2)
                       + {{24{terms.t3[7]}}, terms.t3};
    integ_two_next = integ_two + (integ_one << 3) + {{25{terms.t2[6]}}, terms.t2};
    integ_one_next = integ_one + {{27{terms.t1[4]}}, terms.t1};
    byte_counter_next = byte_counter + 7'd1;
  end

  // A zero ratio compares true on every byte, as a ratio of one does.
  assign fire = byte_counter_next >= decimation_bytes;
  assign push = accept && fire;
  assign push_data = integ_three_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      integ_one <= '0;
      integ_two <= '0;
      integ_three <= '0;
      byte_counter <= '0;
    end else if (accept) begin
      integ_one <= integ_one_next;
      integ_two <= integ_two_next;
      integ_three <= integ_three_next;
      byte_counter <= fire ? 7'd0 : byte_counter_next;
    end
  end

  a_counter_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && fire) |=> (byte_counter == 7'd0))
    else $error("byte counter did not restart after a decimation point");

endmodule

`default_nettype wire

### src/pcd_fifo.sv
// Short queue of integrator snapshots between the front and the filter back.
// Flop storage, one read address. Uses pcd_pkg.
`default_nettype none

module pcd_fifo (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    push,
  input  wire logic [31:0]             push_data,
  input  wire logic                    pop,
  output logic [31:0]                  pop_data,
  output pcd_pkg::pcd_fifo_stat_t      stat
);

  logic [31:0]                  mem [pcd_pkg::FifoDepth];
  logic [pcd_pkg::FifoAw-1:0]   wr_ptr;
  logic [pcd_pkg::FifoAw-1:0]   rd_ptr;
  logic [pcd_pkg::FifoAw:0]     count;

  assign pop_data = mem[rd_ptr];
  assign stat.full = count == (pcd_pkg::FifoAw + 1)'(pcd_pkg::FifoDepth);
  assign stat.empty = count == '0;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && stat.full))
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && stat.empty))
    else $error("pop from an empty queue");

endmodule

`default_nettype wire

### src/pcd_back.sv
// Filter back of the decimator: three comb stages, DC-blocking high-pass,
// exponential low-pass, scaling and saturation into an output register. Uses pcd_pkg.
`default_nettype none

module pcd_back (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire pcd_pkg::pcd_fifo_stat_t stat,
  output logic                         pop,
  input  wire logic [31:0]             pop_data,
  input  wire logic [15:0]             sample_limit,
  output logic                         m_tvalid,
  input  wire logic                    m_tready,
  output logic [15:0]                  m_tdata     // [15:0] pcm_sample
);

  logic        en;
  logic        v1;
  logic        v2;
  logic        v3;
  logic        v4;
  logic        v5;
  logic [31:0] c1;
  logic [31:0] c2;
  logic [31:0] c3;
  logic [31:0] comb_delay_one;
  logic [31:0] comb_delay_two;
  logic [31:0] comb_delay_three;
  logic signed [31:0] highpass_prev_in;
  logic signed [31:0] highpass_prev_out;
  logic signed [31:0] lowpass_acc;
  logic signed [31:0] hp_y;
  logic signed [31:0] lp_diff;
  logic signed [31:0] scaled;
  logic [15:0] sat_value;
  logic [15:0] samples_emitted;
  logic        emit;

  // The whole chain moves together whenever the output register can load.
  assign en = !m_tvalid || m_tready;
  assign pop = en && !stat.empty;
  assign emit = v3 && (samples_emitted < sample_limit);

  always_comb begin
    hp_y = $signed(c3) - highpass_prev_in + highpass_prev_out
           - (highpass_prev_out >>> pcd_pkg::HpShift);
    lp_diff = highpass_prev_out - lowpass_acc;
    scaled = lowpass_acc >>> pcd_pkg::OutShift;
    if (scaled > pcd_pkg::PcmMax) begin
      sat_value = pcd_pkg::PcmMax[15:0];
    end else if (scaled < pcd_pkg::PcmMin) begin
      sat_value = pcd_pkg::PcmMin[15:0];
    end else begin
      sat_value = scaled[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      m_tvalid <= 1'b0;
      comb_delay_one <= '0;
      comb_delay_two <= '0;
      comb_delay_three <= '0;
      highpass_prev_in <= '0;
      highpass_prev_out <= '0;
      lowpass_acc <= '0;
      samples_emitted <= '0;
    end else if (en) begin
      v1 <= pop;
      v2 <= v1;
      v3 <= v2;
      v4 <= emit;
      v5 <= v4;
      m_tvalid <= v5;
      if (pop) begin
        comb_delay_one <= pop_data;
      end
      if (v1) begin
        comb_delay_two <= c1;
      end
      if (v2) begin
        comb_delay_three <= c2;
      end
      if (emit) begin
        highpass_prev_in <= $signed(c3);
        highpass_prev_out <= hp_y;
        samples_emitted <= samples_emitted + 16'd1;
      end
      if (v4) begin
        lowpass_acc <= lowpass_acc + (lp_diff >>> pcd_pkg::LpShift);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1 <= pop_data - comb_delay_one;
      c2 <= c1 - comb_delay_two;
      c3 <= c2 - comb_delay_three;
      m_tdata <= sat_value;
    end
  end

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    !en |=> ($stable(highpass_prev_out) && $stable(lowpass_acc) && $stable(samples_emitted)))
    else $error("filter state moved while the output was stalled");

  a_emit_marks: assert property (@(posedge clk) disable iff (rst)
    (en && emit) |=> (v4 && samples_emitted == $past(samples_emitted) + 16'd1))
    else $error("emitted sample not tracked");

  a_limit_blocks: assert property (@(posedge clk) disable iff (rst)
    (en && v3 && !emit) |=> !v4)
    else $error("sample passed the limit");

endmodule

`default_nettype wire
